// ----- design/stt_pkg.sv -----
// shared types and constants for the step toward target unit
package stt_pkg;

   localparam int COORD_W    = 24;
   localparam int STEP_REG_W = 16;
   localparam int DELTA_W    = COORD_W + 1;
   localparam int SUM_W      = 2 * DELTA_W;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 1;
   localparam int TRIAL_W    = ROOT_W + 3;
   localparam int CNT_W      = $clog2(ROOT_W + 1);
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_X    = 2'd0,
      CSR_TARGET_Y    = 2'd1,
      CSR_STEP_LENGTH = 2'd2
   } stt_csr_type;

   localparam logic [STEP_REG_W-1:0] STEP_RESET = 16'd768;

   typedef enum logic {
      OP_SQRT = 1'b0,
      OP_DIV  = 1'b1
   } stt_op_type;

   typedef struct packed {
      logic       start;
      stt_op_type op;
   } stt_cmd_type;

endpackage

// ----- design/stt_root_div.sv -----
// bit-serial square root and divider sharing one trial subtractor
module stt_root_div
   import stt_pkg::*;
#(
   parameter int QUO_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  stt_cmd_type       cmd,
   input  logic [SUM_W-1:0]  operand,
   input  logic [ROOT_W-1:0] divisor,
   output logic              done,
   output logic [ROOT_W-1:0] result
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   stt_op_type         op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SUM_W-1:0]   work_ff, work_in;

   logic [TRIAL_W-1:0] rem_cat;
   logic [TRIAL_W-1:0] trial;
   logic [TRIAL_W:0]   diff;
   logic               fits;

   always_comb begin
      if (op_ff == OP_SQRT) begin
         rem_cat = {rem_ff, work_ff[SUM_W-1 -: 2]};
         trial   = {1'b0, root_ff, 2'b01};
      end else begin
         rem_cat = {1'b0, rem_ff, work_ff[SUM_W-1]};
         trial   = {3'b000, divisor};
      end
      diff = {1'b0, rem_cat} - {1'b0, trial};
      fits = !diff[TRIAL_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      work_in = work_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         root_in = '0;
         if (cmd.op == OP_SQRT) begin
            cnt_in  = CNT_W'(SUM_W / 2);
            rem_in  = '0;
            work_in = operand;
         end else begin
            cnt_in  = CNT_W'(QUO_BITS);
            rem_in  = REM_W'(operand >> QUO_BITS);
            work_in = operand << (SUM_W - QUO_BITS);
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[REM_W-1:0] : rem_cat[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         work_in = (op_ff == OP_SQRT) ? (work_ff << 2) : (work_ff << 1);
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_SQRT;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      work_ff <= work_in;
   end

   assign done   = done_ff;
   assign result = root_ff;

endmodule

// ----- design/step_toward_target_unit.sv -----
// constant-speed 2-d move toward a configured target point
//
//   channel | dir | tdata / data                      | tuser
//   req_    | in  | [23:0] load_x, [47:24] load_y     | action
//   rsp_    | out | [23:0] pos_x, [47:24] pos_y       | arrived
//   csr_    | in  | csr_index 0..2, csr_data [23:0]   | -
//
// a load beat goes straight from idle to finish; a step beat that snaps onto the target
// passes delta, sq_x, sq_y, sq_s and cmp before finish; a full step adds the square
// root and two quotient passes of COORD_FRAC_BITS + 8 bits on the shared unit.
// req_tready is high only between beats; a waiting rsp beat does not block the next req.
// reset is synchronous and clears position and target, step length returns to 768.
module step_toward_target_unit
   import stt_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // load_x, load_y
   input  logic                 req_tuser,   // action
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // pos_x, pos_y
   output logic                 rsp_tuser,   // arrived
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_data
);

   localparam int STEP_W      = COORD_FRAC_BITS + 8;
   localparam int STEP_WIDE_W = STEP_REG_W + COORD_FRAC_BITS;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_DELTA  = 14'b00000000000010,
      S_SQ_X   = 14'b00000000000100,
      S_SQ_Y   = 14'b00000000001000,
      S_SQ_S   = 14'b00000000010000,
      S_CMP    = 14'b00000000100000,
      S_ROOT   = 14'b00000001000000,
      S_MUL_X  = 14'b00000010000000,
      S_KICK_X = 14'b00000100000000,
      S_DIV_X  = 14'b00001000000000,
      S_MUL_Y  = 14'b00010000000000,
      S_KICK_Y = 14'b00100000000000,
      S_DIV_Y  = 14'b01000000000000,
      S_FINISH = 14'b10000000000000
   } state_type;

   state_type              state_ff, state_in;
   logic [COORD_W-1:0]     tgt_x_ff, tgt_x_in;
   logic [COORD_W-1:0]     tgt_y_ff, tgt_y_in;
   logic [STEP_REG_W-1:0]  step_len_ff, step_len_in;
   logic [COORD_W-1:0]     cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]     cur_y_ff, cur_y_in;
   logic [DELTA_W-1:0]     ax_ff, ax_in;
   logic [DELTA_W-1:0]     ay_ff, ay_in;
   logic                   neg_x_ff, neg_x_in;
   logic                   neg_y_ff, neg_y_in;
   logic [SUM_W-1:0]       prod_ff, prod_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [ROOT_W-1:0]      dist_ff, dist_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2*COORD_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;

   logic [STEP_WIDE_W-1:0] step_wide;
   logic [ROOT_W-1:0]      step;
   logic [DELTA_W-1:0]     dx, dy;
   logic [DELTA_W-1:0]     mul_a, mul_b;
   stt_cmd_type            unit_cmd;
   logic                   unit_done;
   logic [ROOT_W-1:0]      unit_result;
   logic [COORD_W-1:0]     quo;

   assign step_wide = STEP_WIDE_W'(step_len_ff) << COORD_FRAC_BITS;
   assign step      = ROOT_W'(step_wide[STEP_WIDE_W-1:8]);
   assign dx        = {tgt_x_ff[COORD_W-1], tgt_x_ff} - {cur_x_ff[COORD_W-1], cur_x_ff};
   assign dy        = {tgt_y_ff[COORD_W-1], tgt_y_ff} - {cur_y_ff[COORD_W-1], cur_y_ff};
   assign quo       = unit_result[COORD_W-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_SQ_X:  begin mul_a = ax_ff; mul_b = ax_ff; end
         S_SQ_Y:  begin mul_a = ay_ff; mul_b = ay_ff; end
         S_MUL_X: begin mul_a = ax_ff; mul_b = step;  end
         S_MUL_Y: begin mul_a = ay_ff; mul_b = step;  end
         default: begin mul_a = step;  mul_b = step;  end
      endcase
   end

   always_comb begin
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      step_len_in  = step_len_ff;
      state_in     = state_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      prod_in      = mul_a * mul_b;
      sum_in       = sum_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unit_cmd     = '{start: 1'b0, op: OP_SQRT};

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_X:    tgt_x_in    = csr_data;
            CSR_TARGET_Y:    tgt_y_in    = csr_data;
            CSR_STEP_LENGTH: step_len_in = csr_data[STEP_REG_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  state_in = S_DELTA;
               end else begin
                  cur_x_in = req_tdata[COORD_W-1:0];
                  cur_y_in = req_tdata[2*COORD_W-1:COORD_W];
                  state_in = S_FINISH;
               end
            end
         end
         S_DELTA: begin
            neg_x_in = dx[DELTA_W-1];
            neg_y_in = dy[DELTA_W-1];
            ax_in    = dx[DELTA_W-1] ? -dx : dx;
            ay_in    = dy[DELTA_W-1] ? -dy : dy;
            state_in = S_SQ_X;
         end
         S_SQ_X: state_in = S_SQ_Y;
         S_SQ_Y: begin
            sum_in   = prod_ff;
            state_in = S_SQ_S;
         end
         S_SQ_S: begin
            sum_in   = sum_ff + prod_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sum_ff <= prod_ff) begin
               cur_x_in = tgt_x_ff;
               cur_y_in = tgt_y_ff;
               state_in = S_FINISH;
            end else begin
               unit_cmd = '{start: 1'b1, op: OP_SQRT};
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (unit_done) begin
               dist_in  = (unit_result == '0) ? ROOT_W'(1) : unit_result;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: state_in = S_KICK_X;
         S_KICK_X: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            state_in = S_DIV_X;
         end
         S_DIV_X: begin
            if (unit_done) begin
               cur_x_in = neg_x_ff ? (cur_x_ff - quo) : (cur_x_ff + quo);
               state_in = S_MUL_Y;
            end
         end
         S_MUL_Y: state_in = S_KICK_Y;
         S_KICK_Y: begin
            unit_cmd = '{start: 1'b1, op: OP_DIV};
            state_in = S_DIV_Y;
         end
         S_DIV_Y: begin
            if (unit_done) begin
               cur_y_in = neg_y_ff ? (cur_y_ff - quo) : (cur_y_ff + quo);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cur_y_ff, cur_x_ff};
               rsp_user_in  = (cur_x_ff == tgt_x_ff) && (cur_y_ff == tgt_y_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tgt_x_ff     <= '0;
         tgt_y_ff     <= '0;
         step_len_ff  <= STEP_RESET;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         step_len_ff  <= step_len_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   stt_root_div #(
      .QUO_BITS (STEP_W)
   ) u_root_div (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .operand (unit_cmd.op == OP_SQRT ? sum_ff : prod_ff),
      .divisor (dist_ff),
      .done    (unit_done),
      .result  (unit_result)
   );

endmodule

// ----- tb/sv/tb.sv -----
// testbench for step_toward_target_unit: random loads and steps checked against a predictor
module tb;
   import stt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS = 8;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam bit ACT_LOAD = 1'b0;
   localparam bit ACT_STEP = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic               arrived;
   } pos_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_data = '0;

   logic [COORD_W-1:0]    goal_x, goal_y, track_x, track_y;
   logic [STEP_REG_W-1:0] max_step;
   pos_beat_type          pending_pos_q[$];
   int                    mismatches = 0;
   int                    cycle_count = 0;
   int                    burst_left = 0;

   step_toward_target_unit #(
      .COORD_FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver stall pattern: always ready, random, or mostly stalled
   always @(posedge clock) begin : rsp_stall
      int mode;
      int mode_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      pos_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pos_q.size() == 0) begin
            $error("result beat with no expected position pending");
            mismatches++;
         end else begin
            want = pending_pos_q.pop_front();
            if (rsp_tdata[23:0] !== want.pos_x) begin
               $error("pos_x expected %h actual %h", want.pos_x, rsp_tdata[23:0]);
               mismatches++;
            end
            if (rsp_tdata[47:24] !== want.pos_y) begin
               $error("pos_y expected %h actual %h", want.pos_y, rsp_tdata[47:24]);
               mismatches++;
            end
            if (rsp_tuser !== want.arrived) begin
               $error("arrived expected %b actual %b", want.arrived, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   function automatic longint floor_root(input longint v);
      longint root;
      longint b;
      root = 0;
      b = longint'(1) << 62;
      while (b > v)
         b >>= 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint axis_move(input longint delta, input longint stp, input longint d);
      longint mag;
      longint q;
      mag = (delta < 0) ? -delta : delta;
      q = (mag * stp) / d;
      return (delta < 0) ? -q : q;
   endfunction

   function automatic void advance_position(input bit action, input logic [COORD_W-1:0] lx,
                                            input logic [COORD_W-1:0] ly);
      longint       px, py, dx, dy, stp, sum, d;
      pos_beat_type beat;
      if (action == ACT_LOAD) begin
         track_x = lx;
         track_y = ly;
      end else begin
         px = $signed(track_x);
         py = $signed(track_y);
         dx = longint'($signed(goal_x)) - px;
         dy = longint'($signed(goal_y)) - py;
         stp = (longint'(max_step) << FRAC_BITS) >> 8;
         sum = dx * dx + dy * dy;
         if (sum <= stp * stp) begin
            track_x = goal_x;
            track_y = goal_y;
         end else begin
            d = floor_root(sum);
            if (d == 0)
               d = 1;
            px += axis_move(dx, stp, d);
            py += axis_move(dy, stp, d);
            track_x = px[23:0];
            track_y = py[23:0];
         end
      end
      beat.pos_x = track_x;
      beat.pos_y = track_y;
      beat.arrived = (track_x == goal_x) && (track_y == goal_y);
      pending_pos_q.push_back(beat);
   endfunction

   task automatic send_beat(input bit action, input logic [COORD_W-1:0] lx,
                            input logic [COORD_W-1:0] ly);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {ly, lx};
      req_tuser <= action;
      do @(posedge clock); while (!req_tready);
      advance_position(action, lx, ly);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_pos_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TARGET_X)
         goal_x = value;
      else if (idx == CSR_TARGET_Y)
         goal_y = value;
      else if (idx == CSR_STEP_LENGTH)
         max_step = value[15:0];
   endtask

   // which: [0] target_x, [1] target_y, [2] step_length, [3] index past the list
   task automatic configure(input bit [3:0] which, input logic [COORD_W-1:0] tx,
                            input logic [COORD_W-1:0] ty, input logic [STEP_REG_W-1:0] st);
      wait_drained();
      if (which[0])
         write_reg(CSR_TARGET_X, tx);
      if (which[1])
         write_reg(CSR_TARGET_Y, ty);
      if (which[2])
         write_reg(CSR_STEP_LENGTH, {8'($urandom), st});
      if (which[3])
         write_reg(CSR_UNUSED, 24'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] center);
      case ($urandom_range(0, 7))
         0: return 24'($urandom);
         1: return 24'h7fffff;
         2: return 24'h800000;
         default: return center + 24'($urandom_range(0, 8000)) - 24'd4000;
      endcase
   endfunction

   function automatic logic [STEP_REG_W-1:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(1, 16));
         3: return 16'($urandom_range(256, 4096));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_reset_state();
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      send_beat(ACT_LOAD, 24'd1000, -24'sd1000);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
   endtask

   task automatic test_extremes();
      configure(4'b0111, 24'h7fffff, 24'h800000, 16'hffff);
      send_beat(ACT_LOAD, 24'h800000, 24'h7fffff);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      // load straight onto the target, then step while already there
      send_beat(ACT_LOAD, 24'h7fffff, 24'h800000);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      // zero step, off and on the target
      configure(4'b0100, 24'd0, 24'd0, 16'h0000);
      send_beat(ACT_LOAD, 24'h000100, 24'hffff00);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      send_beat(ACT_LOAD, goal_x, goal_y);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      // write past the register list is ignored
      configure(4'b1011, 24'd0, 24'd0, 16'h0000);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      // tiny step truncates to no move, then exact snap at equal distance
      configure(4'b0100, 24'd0, 24'd0, 16'd1);
      send_beat(ACT_LOAD, 24'd3, 24'd4);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      configure(4'b0100, 24'd0, 24'd0, 16'd5);
      send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
   endtask

   task automatic test_drain_pause();
      configure(4'b0111, 24'h001000, 24'hfff000, 16'd300);
      send_beat(ACT_LOAD, 24'h000000, 24'h000000);
      repeat (6) send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
      wait_drained();
      repeat (8) send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
   endtask

   task automatic test_random_walks(input int item_goal);
      int                    sent;
      int                    run_len;
      bit [3:0]              which;
      logic [COORD_W-1:0]    tx, ty;
      logic [STEP_REG_W-1:0] st;
      sent = 0;
      while (sent < item_goal) begin
         which = 4'($urandom);
         tx = pick_coord(24'd0);
         ty = pick_coord(24'd0);
         st = pick_step();
         configure(which, tx, ty, st);
         run_len = $urandom_range(8, 40);
         send_beat(ACT_LOAD, pick_coord(goal_x), pick_coord(goal_y));
         for (int i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(ACT_LOAD, pick_coord(goal_x), pick_coord(goal_y));
            else
               send_beat(ACT_STEP, 24'($urandom), 24'($urandom));
         end
         sent += run_len + 1;
      end
   endtask

   initial begin
      goal_x = '0;
      goal_y = '0;
      track_x = '0;
      track_y = '0;
      max_step = STEP_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_extremes();
      test_drain_pause();
      test_random_walks(800);
      wait_drained();
      if (mismatches == 0 && pending_pos_q.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
